[src/lmadd_pkg.sv]
// Shared types and constants for the light moving-average dark detector.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package lmadd_pkg;

  localparam int unsigned SAMPLE_W       = 12;
  localparam int unsigned WINDOW_LEN_DEF = 8;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_DEADBAND = 1'b1;

  localparam logic [SAMPLE_W-1:0] DARK_THRESHOLD_RST  = 12'd1000;
  localparam logic [SAMPLE_W-1:0] CHANGE_DEADBAND_RST = 12'd50;

  // Request types carried in req_type.
  localparam logic REQ_NORMAL = 1'b0;
  localparam logic REQ_CALIB  = 1'b1;

  // Control broadcast from the window to every cell of the row.
  typedef struct packed {
    logic adv;      // an item is taken this cycle
    logic restart;  // calibration item with run_start: pointer back to cell 0
  } lmadd_cell_ctrl_t;

endpackage

`default_nettype wire

[src/lmadd_in_if.sv]
// Input channel interface: valid/ready handshake with one sample request.
// Depends on lmadd_pkg for the sample width.
`default_nettype none

interface lmadd_in_if import lmadd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [SAMPLE_W-1:0] sample;
  logic                run_start;

  modport source (output valid, output req_type, output sample, output run_start,
                  input ready);
  modport sink   (input valid, input req_type, input sample, input run_start,
                  output ready);
endinterface

`default_nettype wire

[src/lmadd_out_if.sv]
// Result channel interface: valid/ready handshake with the reported level and flags.
// Depends on lmadd_pkg for the level width.
`default_nettype none

interface lmadd_out_if import lmadd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] light_level;
  logic                dark_now;
  logic                level_changed;
  logic                bedtime_event;

  modport source (output valid, output light_level, output dark_now,
                  output level_changed, output bedtime_event, input ready);
  modport sink   (input valid, input light_level, input dark_now,
                  input level_changed, input bedtime_event, output ready);
endinterface

`default_nettype wire

[src/lmadd_cfg_if.sv]
// Configuration write channel interface: valid/ready with register index and data.
// Depends on lmadd_pkg for the index and data widths.
`default_nettype none

interface lmadd_cfg_if import lmadd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SAMPLE_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/lmadd_cell.sv]
// One window cell: a stored sample plus the write-pointer token bit.
// Depends on lmadd_pkg; instantiated in a row by lmadd_window.
`default_nettype none

module lmadd_cell import lmadd_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lmadd_cell_ctrl_t    ctrl,
  input  wire logic                tok_prev,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     tok_o,
  output logic [SAMPLE_W-1:0]      data_o
);

  logic                tok_r, tok_nxt;
  logic [SAMPLE_W-1:0] data_r, data_nxt;
  logic                wr_en;

  // A restart writes cell 0 and leaves the token on cell 1.
  always_comb begin
    wr_en    = ctrl.restart ? (INDEX == 0) : tok_r;
    tok_nxt  = ctrl.restart ? (INDEX == 1) : tok_prev;
    data_nxt = wr_en ? sample : data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= (INDEX == 0);
      data_r <= '0;
    end else if (ctrl.adv) begin
      tok_r  <= tok_nxt;
      data_r <= data_nxt;
    end
  end

  assign tok_o  = tok_r;
  assign data_o = data_r;

endmodule

`default_nettype wire

[src/lmadd_window.sv]
// Ring window built as a row of cells that pass the write token to their neighbour.
// Depends on lmadd_pkg and lmadd_cell.
`default_nettype none

module lmadd_window import lmadd_pkg::*; #(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lmadd_cell_ctrl_t    ctrl,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic [SAMPLE_W-1:0]      oldest,
  output logic                     last_tok
);

  logic [WINDOW_LEN-1:0] tok;
  logic [SAMPLE_W-1:0]   data [WINDOW_LEN];

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    lmadd_cell #(.INDEX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .tok_prev (tok[(i + WINDOW_LEN - 1) % WINDOW_LEN]),
      .sample   (sample),
      .tok_o    (tok[i]),
      .data_o   (data[i])
    );
  end

  // The entry under the token is the one about to be overwritten.
  always_comb begin
    oldest = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      oldest = oldest | (data[i] & {SAMPLE_W{tok[i]}});
    end
  end

  assign last_tok = tok[WINDOW_LEN-1];

  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(tok))
    else $error("window write token is not one-hot");

endmodule

`default_nettype wire

[src/light_moving_average_dark_detect_top.sv]
// Light moving-average filter with deadband and dark-transition detection.
// Depends on lmadd_pkg, the three channel interfaces and lmadd_window.
//
// Usage: light ADC samples arrive as transfers on in_ch; each produces exactly one
// result transfer on out_ch carrying the reported light level, whether it is dark,
// whether this sample updated the level, and a bedtime event on a not-dark to dark
// step. Calibration samples (req_type high) prefill the window; run_start on such a
// sample first clears the running sum and the write pointer.
// The result of a sample is loaded into the output register at the edge that takes the
// sample. Throughput is one sample per cycle while the receiver keeps taking results, set
// by the combinational update of the running sum held in the cell row and the sum register.
// The result sits in an output register; a new sample is taken whenever that
// register is empty or is being emptied in the same cycle, so while the receiver
// stalls a waiting result is held and in_ch stays not ready until it is taken.
// Reset (rst_n low, synchronous) clears the window cells, pointer, sum, level and
// primed flag and loads the thresholds with their default values; no clearing pass.
// cfg_ch is always ready; registers should be written only while the block is idle.
`default_nettype none

module light_moving_average_dark_detect_top import lmadd_pkg::*; #(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lmadd_in_if.sink    in_ch,
  lmadd_out_if.source out_ch,
  lmadd_cfg_if.sink   cfg_ch
);

  // The window length must be a power of two so that the mean is a plain shift.
  localparam int unsigned LOG2_LEN = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W    = LOG2_LEN + SAMPLE_W;
  localparam int unsigned EXT_W    = SUM_W + 2;
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW_LEN * ((1 << SAMPLE_W) - 1));

  // Configuration registers.
  logic [SAMPLE_W-1:0] dark_thr_r;
  logic [SAMPLE_W-1:0] deadband_r;

  // Filter state.
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] level_r, level_nxt;
  logic                primed_r, primed_nxt;

  // Output register.
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_level_r;
  logic                out_dark_r;
  logic                out_changed_r, changed_nxt;
  logic                out_bedtime_r, bedtime_nxt;

  logic                in_fire;
  logic                is_calib;
  logic                restart;
  lmadd_cell_ctrl_t    cell_ctrl;
  logic [SAMPLE_W-1:0] oldest;
  logic                last_tok;

  logic signed [EXT_W-1:0] acc;
  logic signed [EXT_W-1:0] base;
  logic signed [EXT_W-1:0] drop;
  logic [SAMPLE_W-1:0]     mean;
  logic [SAMPLE_W-1:0]     diff;
  logic                    was_dark;
  logic                    is_dark;

  // A new sample is taken whenever the output register is free or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_calib    = (in_ch.req_type == REQ_CALIB);
  assign restart     = is_calib && in_ch.run_start;

  assign cell_ctrl.adv     = in_fire;
  assign cell_ctrl.restart = restart;

  lmadd_window #(.WINDOW_LEN(WINDOW_LEN)) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (cell_ctrl),
    .sample   (in_ch.sample),
    .oldest   (oldest),
    .last_tok (last_tok)
  );

  // Running sum: a calibration sample only adds, a normal sample also drops the
  // entry it overwrites. The result is saturated to the range a full window can hold.
  always_comb begin
    base = restart ? '0 : $signed({2'b00, sum_r});
    drop = is_calib ? '0 : $signed({(EXT_W - SAMPLE_W)'(0), oldest});
    acc  = base + $signed({(EXT_W - SAMPLE_W)'(0), in_ch.sample}) - drop;
    if (acc < 0) begin
      sum_nxt = '0;
    end else if (acc > $signed({2'b00, SUM_MAX})) begin
      sum_nxt = SUM_MAX;
    end else begin
      sum_nxt = acc[SUM_W-1:0];
    end
  end

  assign mean = sum_nxt[SUM_W-1 -: SAMPLE_W];

  // Level update: calibration sets it when the window is full, a normal sample
  // sets it first time round or when the mean leaves the deadband.
  always_comb begin
    diff        = (mean > level_r) ? (mean - level_r) : (level_r - mean);
    was_dark    = level_r < dark_thr_r;
    is_dark     = mean < dark_thr_r;
    level_nxt   = level_r;
    primed_nxt  = primed_r;
    changed_nxt = 1'b0;
    bedtime_nxt = 1'b0;
    unique case (in_ch.req_type)
      REQ_CALIB: begin
        if (restart) begin
          primed_nxt = 1'b0;
        end
        // The write that lands in the last cell wraps the pointer back to zero.
        if (!restart && last_tok) begin
          level_nxt   = mean;
          changed_nxt = 1'b1;
        end
      end
      REQ_NORMAL: begin
        primed_nxt = 1'b1;
        if (!primed_r || diff > deadband_r) begin
          level_nxt   = mean;
          changed_nxt = 1'b1;
          bedtime_nxt = !was_dark && is_dark;
        end
      end
      default: begin
        level_nxt = level_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      level_r  <= '0;
      primed_r <= 1'b0;
    end else if (in_fire) begin
      sum_r    <= sum_nxt;
      level_r  <= level_nxt;
      primed_r <= primed_nxt;
    end
  end

  // Output register; the payload is only loaded on an input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_level_r   <= level_nxt;
      out_dark_r    <= level_nxt < dark_thr_r;
      out_changed_r <= changed_nxt;
      out_bedtime_r <= bedtime_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.light_level   = out_level_r;
  assign out_ch.dark_now      = out_dark_r;
  assign out_ch.level_changed = out_changed_r;
  assign out_ch.bedtime_event = out_bedtime_r;

  // Configuration port: always ready, one register per transfer.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_thr_r <= DARK_THRESHOLD_RST;
      deadband_r <= CHANGE_DEADBAND_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DARK_THRESHOLD:  dark_thr_r <= cfg_ch.data;
        REG_CHANGE_DEADBAND: deadband_r <= cfg_ch.data;
        default:             dark_thr_r <= dark_thr_r;
      endcase
    end
  end

  a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n) sum_r <= SUM_MAX)
    else $error("running sum exceeds full-window bound");

  a_bedtime_implies_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bedtime_r |-> out_changed_r && out_dark_r)
    else $error("bedtime event without a level change into dark");

  a_restart_unprimes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && restart |=> !primed_r && (level_r == $past(level_r)))
    else $error("calibration restart did not clear primed or moved the level");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the light moving-average dark detector.
// Depends on lmadd_pkg, the three channel interfaces and the block's top level.
// A short table of opening samples is followed by random runs over several register settings.
module tb_top import lmadd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // The window length is left at the block's default, and the predictor uses the same value.
  localparam int WIN        = WINDOW_LEN_DEF;
  localparam int SUM_CEIL   = WIN * 4095;
  localparam int CYCLE_CAP  = 250000;

  // One result transfer, in the order that the result channel carries its fields.
  typedef struct packed {
    logic [SAMPLE_W-1:0] light_level;
    logic                dark_now;
    logic                level_changed;
    logic                bedtime_event;
  } light_res_t;

  // One row of the opening table. Where pinned is set, the result is typed in by hand and
  // that value is expected instead of the predicted one.
  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sample;
    logic                run_start;
    logic                pinned;
    light_res_t          result;
  } stim_row_t;

  localparam light_res_t NO_PIN = '0;

  // The opening sequence, from reset with the default threshold of 1000 and deadband of 50.
  // It primes the level, prefills the whole window with full-scale calibration samples, walks
  // the mean down through the threshold so that a bedtime event fires, probes the deadband at
  // exactly its edge and one past it, and drives the running sum below zero so that it clamps.
  localparam stim_row_t OPENING_ROWS [23] = '{
    // First sample after reset always updates the level, even to zero.
    '{REQ_NORMAL, 12'd0,    1'b0, 1'b1, '{12'd0,    1'b1, 1'b1, 1'b0}},
    // One full-scale sample in an otherwise empty window moves the mean to 4095 / 8.
    '{REQ_NORMAL, 12'd4095, 1'b0, 1'b1, '{12'd511,  1'b1, 1'b1, 1'b0}},
    // Calibration with a run start: the level holds until the window is full.
    '{REQ_CALIB,  12'd4095, 1'b1, 1'b1, '{12'd511,  1'b1, 1'b0, 1'b0}},
    '{REQ_CALIB,  12'd4095, 1'b0, 1'b0, NO_PIN},
    '{REQ_CALIB,  12'd4095, 1'b0, 1'b0, NO_PIN},
    '{REQ_CALIB,  12'd4095, 1'b0, 1'b0, NO_PIN},
    '{REQ_CALIB,  12'd4095, 1'b0, 1'b0, NO_PIN},
    '{REQ_CALIB,  12'd4095, 1'b0, 1'b0, NO_PIN},
    '{REQ_CALIB,  12'd4095, 1'b0, 1'b0, NO_PIN},
    // The eighth calibration sample fills the window and sets the level to full scale.
    '{REQ_CALIB,  12'd4095, 1'b0, 1'b1, '{12'd4095, 1'b0, 1'b1, 1'b0}},
    // The first normal sample after calibration updates the level unconditionally.
    '{REQ_NORMAL, 12'd4095, 1'b0, 1'b1, '{12'd4095, 1'b0, 1'b1, 1'b0}},
    // A run start on a normal sample must be ignored.
    '{REQ_NORMAL, 12'd0,    1'b1, 1'b0, NO_PIN},
    // Zeros step the mean down by about 511 each time; the next to last of these crosses
    // into the dark.
    '{REQ_NORMAL, 12'd0,    1'b0, 1'b0, NO_PIN},
    '{REQ_NORMAL, 12'd0,    1'b0, 1'b0, NO_PIN},
    '{REQ_NORMAL, 12'd0,    1'b0, 1'b0, NO_PIN},
    '{REQ_NORMAL, 12'd0,    1'b0, 1'b0, NO_PIN},
    '{REQ_NORMAL, 12'd0,    1'b0, 1'b0, NO_PIN},
    '{REQ_NORMAL, 12'd0,    1'b0, 1'b0, NO_PIN},
    '{REQ_NORMAL, 12'd0,    1'b0, 1'b0, NO_PIN},
    // A mean exactly one deadband away holds the level; one more step moves it.
    '{REQ_NORMAL, 12'd400,  1'b0, 1'b0, NO_PIN},
    '{REQ_NORMAL, 12'd8,    1'b0, 1'b0, NO_PIN},
    // A run start empties the sum, so the next normal sample drives it negative.
    '{REQ_CALIB,  12'd0,    1'b1, 1'b0, NO_PIN},
    '{REQ_NORMAL, 12'd0,    1'b0, 1'b0, NO_PIN}
  };

  logic clk;
  logic rst_n;

  lmadd_in_if  in_ch();
  lmadd_out_if out_ch();
  lmadd_cfg_if cfg_ch();

  light_moving_average_dark_detect_top #(.WINDOW_LEN(WIN)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: a private copy of the window, its running sum and the reported level,
  // together with the two register values as last written.
  logic [SAMPLE_W-1:0] win_samples [WIN];
  int                  wr_pos;
  int                  run_sum;
  logic [SAMPLE_W-1:0] shown_level;
  logic                primed_flag;
  logic [SAMPLE_W-1:0] dark_thr;
  logic [SAMPLE_W-1:0] dead_band;

  // Results still owed by the block, oldest first.
  light_res_t level_q [$];

  // Hand-typed result for the sample currently on offer, if any.
  logic       cur_pinned;
  light_res_t cur_pin;

  int  fail_count;
  int  cycles;
  bit  idling;
  int  stall_left;
  int  light_lvl;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int clamp_sum(int s);
    if (s < 0) return 0;
    if (s > SUM_CEIL) return SUM_CEIL;
    return s;
  endfunction

  // Works out the result of one sample and advances the predictor state. A calibration sample
  // only adds to the sum; a normal one replaces the oldest entry and may move the level.
  function automatic light_res_t filter_light(logic req, logic [SAMPLE_W-1:0] smp, logic start);
    light_res_t r;
    int         mean;
    int         gap;
    logic       was_dark;
    r = '0;
    if (req == REQ_CALIB) begin
      if (start) begin
        run_sum     = 0;
        wr_pos      = 0;
        primed_flag = 1'b0;
      end
      win_samples[wr_pos] = smp;
      run_sum = clamp_sum(run_sum + int'(smp));
      wr_pos  = (wr_pos + 1) % WIN;
      if (wr_pos == 0) begin
        shown_level     = SAMPLE_W'(run_sum / WIN);
        r.level_changed = 1'b1;
      end
    end else begin
      run_sum = clamp_sum(run_sum - int'(win_samples[wr_pos]) + int'(smp));
      win_samples[wr_pos] = smp;
      wr_pos = (wr_pos + 1) % WIN;
      mean = run_sum / WIN;
      gap  = (mean > int'(shown_level)) ? mean - int'(shown_level) : int'(shown_level) - mean;
      if (!primed_flag || gap > int'(dead_band)) begin
        was_dark        = shown_level < dark_thr;
        shown_level     = SAMPLE_W'(mean);
        r.level_changed = 1'b1;
        r.bedtime_event = !was_dark && (shown_level < dark_thr);
      end
      primed_flag = 1'b1;
    end
    r.light_level = shown_level;
    r.dark_now    = shown_level < dark_thr;
    return r;
  endfunction

  // A value within span of centre, kept inside the sample range.
  function automatic int nudge(int centre, int span);
    int v;
    v = centre + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // Monitor. Everything is sampled at the rising edge: a configuration transfer updates the
  // predictor's registers, an input transfer queues its expected result, and an output
  // transfer is checked field by field against the oldest result still owed.
  always @(posedge clk) begin
    light_res_t want;
    light_res_t got;
    cycles = cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timed out with %0d results outstanding", $time, level_q.size());
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DARK_THRESHOLD:  dark_thr  = cfg_ch.data;
          REG_CHANGE_DEADBAND: dead_band = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        want = filter_light(in_ch.req_type, in_ch.sample, in_ch.run_start);
        if (cur_pinned) want = cur_pin;
        level_q.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.light_level, out_ch.dark_now, out_ch.level_changed, out_ch.bedtime_event};
        if (level_q.size() == 0) begin
          $display("%0t: result with nothing owed, got level %0d dark %0d changed %0d bed %0d",
                   $time, got.light_level, got.dark_now, got.level_changed, got.bedtime_event);
          fail_count++;
        end else begin
          want = level_q.pop_front();
          if (got.light_level !== want.light_level) begin
            $display("%0t: light_level expected %0d, got %0d",
                     $time, want.light_level, got.light_level);
            fail_count++;
          end
          if (got.dark_now !== want.dark_now) begin
            $display("%0t: dark_now expected %0d, got %0d", $time, want.dark_now, got.dark_now);
            fail_count++;
          end
          if (got.level_changed !== want.level_changed) begin
            $display("%0t: level_changed expected %0d, got %0d",
                     $time, want.level_changed, got.level_changed);
            fail_count++;
          end
          if (got.bedtime_event !== want.bedtime_event) begin
            $display("%0t: bedtime_event expected %0d, got %0d",
                     $time, want.bedtime_event, got.bedtime_event);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver. While idling is allowed it drops ready in bursts of random length; otherwise it
  // takes every result as soon as it is offered.
  always @(negedge clk) begin
    if (!idling) begin
      stall_left = 0;
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Offers one sample and returns at the falling edge after its transfer, with valid still
  // high so that back-to-back samples leave no gap. Called at a falling edge.
  task automatic send_sample(input logic req, input logic [SAMPLE_W-1:0] smp, input logic start,
                             input logic pinned, input light_res_t pin_res);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= req;
    in_ch.sample    <= smp;
    in_ch.run_start <= start;
    cur_pinned = pinned;
    cur_pin    = pin_res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering samples and waits until every owed result has arrived.
  // Returns at a falling edge.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic set_registers(input logic [SAMPLE_W-1:0] thr, input logic [SAMPLE_W-1:0] band);
    drain_results();
    write_reg(REG_DARK_THRESHOLD, thr);
    write_reg(REG_CHANGE_DEADBAND, band);
  endtask

  // Random samples in bursts. Most bursts are slow walks of the light level, often started near
  // the dark threshold so that the level keeps crossing it in both directions. Some are
  // calibration runs, mostly a full window opened by a run start, sometimes 1 to 12 long or
  // without the start. The rest are single samples with every field random.
  task automatic random_phase(input int count, input bit allow_idle);
    int sent;
    int pick;
    int len;
    int span;
    int base;
    sent   = 0;
    idling = allow_idle;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : WIN;
        base = $urandom_range(0, 4095);
        for (int k = 0; k < len; k++) begin
          send_sample(REQ_CALIB, SAMPLE_W'(nudge(base, 40)),
                      (k == 0) && ($urandom_range(0, 4) != 0), 1'b0, NO_PIN);
        end
        sent += len;
      end else if (pick < 85) begin
        len = $urandom_range(4, 30);
        case ($urandom_range(0, 2))
          0:       span = 4;
          1:       span = 40;
          default: span = 300;
        endcase
        if ($urandom_range(0, 1) == 1) light_lvl = nudge(int'(dark_thr), 300);
        for (int k = 0; k < len; k++) begin
          light_lvl = nudge(light_lvl, span);
          send_sample(REQ_NORMAL, SAMPLE_W'(light_lvl), $urandom_range(0, 7) == 0,
                      1'b0, NO_PIN);
        end
        sent += len;
      end else begin
        case ($urandom_range(0, 3))
          0:       base = 0;
          1:       base = 4095;
          default: base = $urandom_range(0, 4095);
        endcase
        send_sample(logic'($urandom_range(0, 1)), SAMPLE_W'(base),
                    logic'($urandom_range(0, 1)), 1'b0, NO_PIN);
        sent++;
      end
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_NORMAL;
    in_ch.sample    = '0;
    in_ch.run_start = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_DARK_THRESHOLD;
    cfg_ch.data     = '0;
    cur_pinned      = 1'b0;
    cur_pin         = NO_PIN;
    fail_count      = 0;
    cycles          = 0;
    idling          = 1'b1;
    stall_left      = 0;
    light_lvl       = 2000;

    // The predictor starts from the block's reset state.
    foreach (win_samples[i]) win_samples[i] = '0;
    wr_pos      = 0;
    run_sum     = 0;
    shown_level = '0;
    primed_flag = 1'b0;
    dark_thr    = DARK_THRESHOLD_RST;
    dead_band   = CHANGE_DEADBAND_RST;

    // Reset is held low from the start and released on a falling edge.
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < $size(OPENING_ROWS); r++) begin
      send_sample(OPENING_ROWS[r].req_type, OPENING_ROWS[r].sample, OPENING_ROWS[r].run_start,
                  OPENING_ROWS[r].pinned, OPENING_ROWS[r].result);
    end

    // Random runs at the reset values, the register corners, a threshold of 2000 with no
    // deadband and a random middle setting. The last run restores the defaults, free of idling.
    random_phase(230, 1'b1);
    set_registers(12'd0, 12'd0);
    random_phase(150, 1'b1);
    set_registers(12'd4095, 12'd4095);
    random_phase(150, 1'b1);
    set_registers(12'd2000, 12'd0);
    random_phase(200, 1'b1);
    set_registers(12'd4095, 12'd0);
    random_phase(150, 1'b1);
    set_registers(12'd0, 12'd4095);
    random_phase(100, 1'b1);
    set_registers(SAMPLE_W'($urandom_range(200, 3800)), SAMPLE_W'($urandom_range(0, 100)));
    random_phase(250, 1'b1);
    set_registers(DARK_THRESHOLD_RST, CHANGE_DEADBAND_RST);
    random_phase(350, 1'b0);

    drain_results();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
